[design/i8dq_pkg.sv]
// ----------------------------------------------------------------------------
// i8dq_pkg
// Shared sizes, codes and register map of the int8 dot product requantizer.
// ----------------------------------------------------------------------------
package i8dq_pkg;

  localparam int FILTERS    = 8;
  localparam int GROUPS     = 6;
  localparam int TIME_DEPTH = 1024;

  // field widths
  localparam int KIND_W = 2;
  localparam int FILT_W = 3;
  localparam int GRP_W  = 3;
  localparam int LANE_W = 8;
  localparam int BIAS_W = 32;
  localparam int DIV_W  = 31;
  localparam int TIME_W = 10;
  localparam int OUT_W  = 8;

  // internal widths
  localparam int SUM_W  = 20;
  localparam int PROD_W = 2 * LANE_W;
  localparam int ROW_N  = FILTERS * GROUPS;
  localparam int ROW_W  = $clog2(ROW_N);
  localparam int FCNT_W = $clog2(FILTERS + 1);
  localparam int NUM_W  = BIAS_W + 1;
  localparam int QUO_W  = 32;
  localparam int QCNT_W = $clog2(QUO_W + 1);

  // configuration registers
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;
  localparam int GIU_W   = 3;
  localparam int TS_W    = 11;
  localparam logic REG_GROUPS = 1'b0;
  localparam logic REG_TIME   = 1'b1;
  localparam logic [GIU_W-1:0] GIU_RESET = GIU_W'(6);
  localparam logic [TS_W-1:0]  TS_RESET  = TS_W'(1024);

  // item kinds
  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WEIGHT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SCALE  = 2'd2;

  localparam int CLAMP_HI = 127;

endpackage

[design/i8dq_in_if.sv]
// ----------------------------------------------------------------------------
// i8dq_in_if
// Input channel: sample groups, weight loads and offset/divisor loads.
// ----------------------------------------------------------------------------
interface i8dq_in_if import i8dq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [FILT_W-1:0]        filter_select;
  logic [GRP_W-1:0]         group_select;
  logic signed [LANE_W-1:0] lane_a;
  logic signed [LANE_W-1:0] lane_b;
  logic signed [LANE_W-1:0] lane_c;
  logic signed [LANE_W-1:0] lane_d;
  logic signed [BIAS_W-1:0] bias_value;
  logic [DIV_W-1:0]         divisor_value;

  modport source (output valid, kind, filter_select, group_select, lane_a, lane_b,
                  lane_c, lane_d, bias_value, divisor_value, input ready);
  modport sink   (input valid, kind, filter_select, group_select, lane_a, lane_b,
                  lane_c, lane_d, bias_value, divisor_value, output ready);
endinterface

[design/i8dq_out_if.sv]
// ----------------------------------------------------------------------------
// i8dq_out_if
// Result channel: one requantized byte per filter.
// ----------------------------------------------------------------------------
interface i8dq_out_if import i8dq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [FILT_W-1:0]       filter_out;
  logic [TIME_W-1:0]       time_index;
  logic signed [OUT_W-1:0] out_value;
  logic                    last_of_run;

  modport source (output valid, filter_out, time_index, out_value, last_of_run,
                  input ready);
  modport sink   (input valid, filter_out, time_index, out_value, last_of_run,
                  output ready);
endinterface

[design/i8dq_div.sv]
// ----------------------------------------------------------------------------
// i8dq_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module i8dq_div import i8dq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [QUO_W-1:0] mag,
  input  logic [DIV_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [QUO_W-1:0] quo
);

  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  den_r, den_nxt;
  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic [DIV_W:0]    rem_sh;
  logic [DIV_W:0]    diff;
  logic              fits;

  always_comb begin
    rem_sh = {rem_r, quo_r[QUO_W-1]};
    diff   = rem_sh - {1'b0, den_r};
    fits   = (rem_sh >= {1'b0, den_r});
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      cnt_nxt  = QCNT_W'(QUO_W);
      busy_nxt = 1'b1;
      rem_nxt  = '0;
      den_nxt  = den;
      quo_nxt  = mag;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      quo_nxt = {quo_r[QUO_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == QCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = quo_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without work");
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> cnt_r == '0) else $error("divider count left over");

endmodule

[design/int8_dot_requantize_layer.sv]
// ----------------------------------------------------------------------------
// int8_dot_requantize_layer
// Per-filter int8 dot product over channel groups with requantized output.
// ----------------------------------------------------------------------------
// Items are taken one at a time. A load item is written to its memory as it is
// taken and the block stays ready. For a sample group the weight rows and filter
// sums sit in synchronous memories with separate read and write ports and are
// read, accumulated and written back one filter a cycle. The last group of a
// time sample then runs each filter through a one-bit-per-cycle divider (read,
// offset add, 32 divide steps, output); no item is taken until every filter is
// through, and the output step waits if the result side stalls. The last result
// may still wait in the output register while the next item is taken.
module int8_dot_requantize_layer import i8dq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  i8dq_in_if.sink           in_ch,
  i8dq_out_if.source        out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACC  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_LD   = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  // configuration
  logic [GIU_W-1:0] giu_r;
  logic [TS_W-1:0]  ts_r;
  logic             cfg_wr;
  logic [GIU_W:0]   eff_groups;
  logic [TS_W-1:0]  eff_time;

  // control
  logic [2:0]        state_r, state_nxt;
  logic [FCNT_W-1:0] f_r, f_nxt;
  logic              acc_vld_r, acc_vld_nxt;
  logic [FILT_W-1:0] acc_f_r, acc_f_nxt;
  logic [GRP_W-1:0]  grp_r, grp_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;
  logic [FILTERS-1:0] svld_r, svld_nxt;
  logic              svld_rd_r;

  // item payload
  logic signed [LANE_W-1:0] lane_r [4];

  // memories
  logic [4*LANE_W-1:0]       wmem [ROW_N];
  logic [SUM_W-1:0]          smem [FILTERS];
  logic [BIAS_W+DIV_W-1:0]   cmem [FILTERS];
  logic [4*LANE_W-1:0]       wrd_r;
  logic [SUM_W-1:0]          srd_r;
  logic [BIAS_W+DIV_W-1:0]   crd_r;

  logic              in_acc;
  logic              w_we, c_we, s_we, s_re;
  logic [ROW_W-1:0]  w_waddr, w_raddr;
  logic [FILT_W-1:0] f_idx;
  logic signed [PROD_W-1:0] prod [4];
  logic signed [SUM_W-1:0]  sum_prev, sum_new;
  logic              issue, grp_last;

  // divide step
  logic signed [NUM_W-1:0] num;
  logic [NUM_W-1:0]        num_abs;
  logic                    neg_r, zero_r;
  logic                    div_start, div_busy, div_done;
  logic [QUO_W-1:0]        div_quo;
  logic [DIV_W-1:0]        den;

  // output register
  logic                    ov_r, ov_nxt;
  logic [FILT_W-1:0]       of_r;
  logic [TIME_W-1:0]       ot_r;
  logic signed [OUT_W-1:0] oval_r, oval_nxt;
  logic                    olast_r;
  logic                    out_load;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      giu_r <= GIU_RESET;
      ts_r  <= TS_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_GROUPS) begin
        giu_r <= cfg_pwdata[GIU_W-1:0];
      end else begin
        ts_r <= cfg_pwdata[TS_W-1:0];
      end
    end
  end

  always_comb begin
    if (cfg_paddr[2] == REG_TIME) begin
      cfg_prdata = {{(CFG_DW-TS_W){1'b0}}, ts_r};
    end else begin
      cfg_prdata = {{(CFG_DW-GIU_W){1'b0}}, giu_r};
    end
  end

  always_comb begin
    priority if (giu_r == '0) begin
      eff_groups = (GIU_W+1)'(1);
    end else if (int'(giu_r) > GROUPS) begin
      eff_groups = (GIU_W+1)'(GROUPS);
    end else begin
      eff_groups = {1'b0, giu_r};
    end
    priority if (ts_r == '0) begin
      eff_time = TS_W'(1);
    end else if (int'(ts_r) > TIME_DEPTH) begin
      eff_time = TS_W'(TIME_DEPTH);
    end else begin
      eff_time = ts_r;
    end
  end

  // ---------------- memories ----------------
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign w_we = in_acc && (in_ch.kind == KIND_WEIGHT) &&
                (int'(in_ch.filter_select) < FILTERS) && (int'(in_ch.group_select) < GROUPS);
  assign c_we = in_acc && (in_ch.kind == KIND_SCALE) &&
                (int'(in_ch.filter_select) < FILTERS);
  assign w_waddr = ROW_W'(int'(in_ch.filter_select) * GROUPS + int'(in_ch.group_select));
  assign f_idx   = f_r[FILT_W-1:0];
  assign w_raddr = ROW_W'(int'(f_idx) * GROUPS + int'(grp_r));
  assign issue   = (state_r == S_ACC) && (int'(f_r) < FILTERS);
  assign s_re    = issue || (state_r == S_RD);
  assign s_we    = acc_vld_r;

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[w_waddr] <= {in_ch.lane_d, in_ch.lane_c, in_ch.lane_b, in_ch.lane_a};
    end
    if (issue) begin
      wrd_r <= wmem[w_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      cmem[in_ch.filter_select] <= {in_ch.bias_value, in_ch.divisor_value};
    end
    if (state_r == S_RD) begin
      crd_r <= cmem[f_idx];
    end
  end

  // sums: reset value comes from the valid bits, not the array
  always_ff @(posedge clk) begin
    if (s_we) begin
      smem[acc_f_r] <= sum_new;
    end
    if (s_re) begin
      srd_r     <= smem[f_idx];
      svld_rd_r <= svld_r[f_idx];
    end
  end

  // ---------------- accumulate ----------------
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      prod[k] = lane_r[k] * $signed(wrd_r[k*LANE_W +: LANE_W]);
    end
    sum_prev = svld_rd_r ? $signed(srd_r) : '0;
    sum_new  = sum_prev + SUM_W'(prod[0]) + SUM_W'(prod[1]) +
               SUM_W'(prod[2]) + SUM_W'(prod[3]);
    grp_last = ({1'b0, grp_r} + 1'b1) >= eff_groups;
  end

  // ---------------- requantize ----------------
  always_comb begin
    num       = NUM_W'($signed(srd_r & {SUM_W{svld_rd_r}})) +
                NUM_W'($signed(crd_r[BIAS_W+DIV_W-1:DIV_W]));
    num_abs   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    den       = crd_r[DIV_W-1:0];
    div_start = (state_r == S_LD);
  end

  i8dq_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .mag   (num_abs[QUO_W-1:0]),
    .den   (den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    priority if (zero_r) begin
      oval_nxt = '0;
    end else if (neg_r) begin
      oval_nxt = (div_quo > QUO_W'(CLAMP_HI + 1)) ? OUT_W'(-CLAMP_HI - 1)
                                                   : OUT_W'(-div_quo);
    end else begin
      oval_nxt = (div_quo > QUO_W'(CLAMP_HI)) ? OUT_W'(CLAMP_HI) : div_quo[OUT_W-1:0];
    end
  end

  assign out_load = (state_r == S_OUT) && (!ov_r || out_ch.ready);

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt   = state_r;
    f_nxt       = f_r;
    acc_vld_nxt = issue;
    acc_f_nxt   = f_idx;
    grp_nxt     = grp_r;
    time_nxt    = time_r;
    svld_nxt    = svld_r;
    ov_nxt      = ov_r && !out_ch.ready;
    if (s_we) begin
      svld_nxt[acc_f_r] = 1'b1;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_ch.kind == KIND_SAMPLE) begin
          state_nxt = S_ACC;
          f_nxt     = '0;
        end
      end
      S_ACC: begin
        if (issue) begin
          f_nxt = f_r + 1'b1;
        end
        if (acc_vld_r && int'(acc_f_r) == FILTERS - 1) begin
          f_nxt = '0;
          if (grp_last) begin
            grp_nxt   = '0;
            state_nxt = S_RD;
          end else begin
            grp_nxt   = grp_r + 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_RD:  state_nxt = S_LD;
      S_LD:  state_nxt = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          ov_nxt = 1'b1;
          if (int'(f_r) == FILTERS - 1) begin
            svld_nxt  = '0;
            state_nxt = S_IDLE;
            time_nxt  = ((TS_W'(time_r) + 1'b1) >= eff_time) ? '0 : time_r + 1'b1;
          end else begin
            f_nxt     = f_r + 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      f_r       <= '0;
      acc_vld_r <= 1'b0;
      grp_r     <= '0;
      time_r    <= '0;
      svld_r    <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      f_r       <= f_nxt;
      acc_vld_r <= acc_vld_nxt;
      grp_r     <= grp_nxt;
      time_r    <= time_nxt;
      svld_r    <= svld_nxt;
      ov_r      <= ov_nxt;
    end
    acc_f_r <= acc_f_nxt;
    if (in_acc) begin
      lane_r[0] <= in_ch.lane_a;
      lane_r[1] <= in_ch.lane_b;
      lane_r[2] <= in_ch.lane_c;
      lane_r[3] <= in_ch.lane_d;
    end
    if (state_r == S_LD) begin
      neg_r  <= num[NUM_W-1];
      zero_r <= (num == '0);
    end
    if (out_load) begin
      of_r    <= f_idx;
      ot_r    <= time_r;
      oval_r  <= oval_nxt;
      olast_r <= (int'(f_r) == FILTERS - 1);
    end
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.filter_out  = of_r;
  assign out_ch.time_index  = ot_r;
  assign out_ch.out_value   = oval_r;
  assign out_ch.last_of_run = olast_r;

  a_last_filter: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.last_of_run |-> int'(out_ch.filter_out) == FILTERS - 1)
    else $error("last item not on final filter");
  a_grp_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(grp_r) < GROUPS) else $error("group count out of range");
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(time_r) < TIME_DEPTH) else $error("time count out of range");
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT |-> !div_busy) else $error("output step with divider busy");

endmodule
